[rtl/bls_pkg.sv]
// Shared constants for the line stepper: coordinate width default, action and octant codes.
`default_nettype none
package bls_pkg;

  // default coordinate width
  localparam int unsigned CoordBitsDef = 12;

  // action field codes
  localparam logic ActStart = 1'b0;
  localparam logic ActStep  = 1'b1;

  // octant modes held in the raster state
  localparam int unsigned ModeBits = 3;
  localparam logic [ModeBits-1:0] ModeHorz       = 3'd0;
  localparam logic [ModeBits-1:0] ModeVert       = 3'd1;
  localparam logic [ModeBits-1:0] ModeDiag       = 3'd2;
  localparam logic [ModeBits-1:0] ModeShallowUp  = 3'd3;
  localparam logic [ModeBits-1:0] ModeShallowDn  = 3'd4;
  localparam logic [ModeBits-1:0] ModeSteepUp    = 3'd5;
  localparam logic [ModeBits-1:0] ModeSteepDn    = 3'd6;

endpackage : bls_pkg
`default_nettype wire

[rtl/bresenham_line_stepper_core.sv]
// Path: input register, one pass of stepping logic, output register.
// Throughput: one word per cycle while the output register is not stalled.
// A word waits in the input register only while the output register is full and stalled.
// Reset (rst_ni low, asynchronous) empties both registers and leaves the stepper idle
// with all line state zero.
`default_nettype none
module bresenham_line_stepper_core import bls_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire logic                  action_i,
  input  wire logic [COORD_BITS-1:0] start_x_i,
  input  wire logic [COORD_BITS-1:0] start_y_i,
  input  wire logic [COORD_BITS-1:0] end_x_i,
  input  wire logic [COORD_BITS-1:0] end_y_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic                  pixel_valid_o,
  output      logic [COORD_BITS-1:0] pixel_x_o,
  output      logic [COORD_BITS-1:0] pixel_y_o,
  output      logic                  last_pixel_o
);

  logic                  advance, fire;
  logic                  h_action;
  logic [COORD_BITS-1:0] h_sx, h_sy, h_ex, h_ey;
  logic                  r_pv, r_last;
  logic [COORD_BITS-1:0] r_px, r_py;

  // hold the incoming word
  bls_in_stage #(.COORD_BITS(COORD_BITS)) u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .start_x_i  (start_x_i),
    .start_y_i  (start_y_i),
    .end_x_i    (end_x_i),
    .end_y_i    (end_y_i),
    .advance_i  (advance),
    .fire_o     (fire),
    .action_o   (h_action),
    .start_x_o  (h_sx),
    .start_y_o  (h_sy),
    .end_x_o    (h_ex),
    .end_y_o    (h_ey)
  );

  // compute the next pixel and advance line state
  bls_raster #(.COORD_BITS(COORD_BITS)) u_raster (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .action_i      (h_action),
    .start_x_i     (h_sx),
    .start_y_i     (h_sy),
    .end_x_i       (h_ex),
    .end_y_i       (h_ey),
    .pixel_valid_o (r_pv),
    .pixel_x_o     (r_px),
    .pixel_y_o     (r_py),
    .last_pixel_o  (r_last)
  );

  // register the result word
  bls_out_stage #(.COORD_BITS(COORD_BITS)) u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (fire),
    .advance_o     (advance),
    .pixel_valid_i (r_pv),
    .pixel_x_i     (r_px),
    .pixel_y_i     (r_py),
    .last_pixel_i  (r_last),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_valid_o (pixel_valid_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .last_pixel_o  (last_pixel_o)
  );

endmodule : bresenham_line_stepper_core
`default_nettype wire

[rtl/bls_in_stage.sv]
// Input register of the line stepper: holds one accepted word until the raster takes it.
`default_nettype none
module bls_in_stage import bls_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire logic                  action_i,
  input  wire logic [COORD_BITS-1:0] start_x_i,
  input  wire logic [COORD_BITS-1:0] start_y_i,
  input  wire logic [COORD_BITS-1:0] end_x_i,
  input  wire logic [COORD_BITS-1:0] end_y_i,
  input  wire logic                  advance_i,
  output      logic                  fire_o,
  output      logic                  action_o,
  output      logic [COORD_BITS-1:0] start_x_o,
  output      logic [COORD_BITS-1:0] start_y_o,
  output      logic [COORD_BITS-1:0] end_x_o,
  output      logic [COORD_BITS-1:0] end_y_o
);

  logic                  vld_q;
  logic                  action_q;
  logic [COORD_BITS-1:0] sx_q, sy_q, ex_q, ey_q;
  logic                  take;

  // accept when empty or when the held word moves on this cycle
  assign in_ready_o = !vld_q || advance_i;
  assign take       = in_valid_i && in_ready_o;
  assign fire_o     = vld_q && advance_i;

  // hold the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (take) begin
      vld_q <= 1'b1;
    end else if (fire_o) begin
      vld_q <= 1'b0;
    end
  end

  // capture the payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      action_q <= action_i;
      sx_q     <= start_x_i;
      sy_q     <= start_y_i;
      ex_q     <= end_x_i;
      ey_q     <= end_y_i;
    end
  end

  assign action_o  = action_q;
  assign start_x_o = sx_q;
  assign start_y_o = sy_q;
  assign end_x_o   = ex_q;
  assign end_y_o   = ey_q;

endmodule : bls_in_stage
`default_nettype wire

[rtl/bls_raster.sv]
// Line state and next-pixel logic: endpoint ordering, octant choice and midpoint stepping.
`default_nettype none
module bls_raster import bls_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  fire_i,
  input  wire logic                  action_i,
  input  wire logic [COORD_BITS-1:0] start_x_i,
  input  wire logic [COORD_BITS-1:0] start_y_i,
  input  wire logic [COORD_BITS-1:0] end_x_i,
  input  wire logic [COORD_BITS-1:0] end_y_i,
  output      logic                  pixel_valid_o,
  output      logic [COORD_BITS-1:0] pixel_x_o,
  output      logic [COORD_BITS-1:0] pixel_y_o,
  output      logic                  last_pixel_o
);

  localparam int unsigned DeltaW = COORD_BITS + 1;
  localparam int unsigned DecW   = COORD_BITS + 4;

  logic [COORD_BITS-1:0]    cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
  logic [COORD_BITS-1:0]    cur_x_d, cur_y_d, tgt_x_d, tgt_y_d;
  logic signed [DecW-1:0]   dec_q, dec_d;
  logic [DeltaW-1:0]        da_q, da_d;
  logic signed [DeltaW-1:0] db_q, db_d;
  logic [ModeBits-1:0]      mode_q, mode_d;
  logic                     busy_q, busy_d;

  // start path signals
  logic                     swap;
  logic [COORD_BITS-1:0]    sx, sy, ex, ey;
  logic signed [DeltaW-1:0] s_da, s_db;
  logic [DeltaW-1:0]        s_ady;
  logic signed [DecW-1:0]   s_daw, s_dbw;

  // step path signals
  logic signed [DecW-1:0]   daw, dbw;
  logic [COORD_BITS-1:0]    x_inc, y_inc, y_dec, y_step;
  logic                     step_last;

  // order endpoints left to right, bottom to top when vertical
  always_comb begin
    swap = (start_x_i == end_x_i) ? ($signed(start_y_i) > $signed(end_y_i))
                                  : ($signed(start_x_i) > $signed(end_x_i));
    sx = swap ? end_x_i   : start_x_i;
    sy = swap ? end_y_i   : start_y_i;
    ex = swap ? start_x_i : end_x_i;
    ey = swap ? start_y_i : end_y_i;
    s_da  = DeltaW'($signed(ex)) - DeltaW'($signed(sx));
    s_db  = DeltaW'($signed(ey)) - DeltaW'($signed(sy));
    s_ady = s_db[DeltaW-1] ? DeltaW'(-s_db) : DeltaW'(s_db);
    s_daw = DecW'(s_da);
    s_dbw = DecW'(s_db);
  end

  // stepping operands
  always_comb begin
    daw    = DecW'($signed({1'b0, da_q}));
    dbw    = DecW'(db_q);
    x_inc  = cur_x_q + 1'b1;
    y_inc  = cur_y_q + 1'b1;
    y_dec  = cur_y_q - 1'b1;
    y_step = db_q[DeltaW-1] ? y_dec : y_inc;
  end

  // next state and result
  always_comb begin
    cur_x_d       = cur_x_q;
    cur_y_d       = cur_y_q;
    tgt_x_d       = tgt_x_q;
    tgt_y_d       = tgt_y_q;
    dec_d         = dec_q;
    da_d          = da_q;
    db_d          = db_q;
    mode_d        = mode_q;
    busy_d        = busy_q;
    step_last     = 1'b1;
    pixel_valid_o = 1'b0;
    pixel_x_o     = '0;
    pixel_y_o     = '0;
    last_pixel_o  = 1'b0;

    if (action_i == ActStart) begin
      // load a new line and give its first pixel
      cur_x_d = sx;
      cur_y_d = sy;
      tgt_x_d = ex;
      tgt_y_d = ey;
      da_d    = DeltaW'(s_da);
      db_d    = s_db;
      dec_d   = '0;
      mode_d  = ModeHorz;
      if (s_da == '0 && s_db == '0) begin
        busy_d       = 1'b0;
        last_pixel_o = 1'b1;
      end else begin
        busy_d = 1'b1;
        if (s_db == '0) begin
          mode_d = ModeHorz;
        end else if (s_da == '0) begin
          mode_d = ModeVert;
        end else if (s_ady == DeltaW'(s_da)) begin
          mode_d = ModeDiag;
        end else if (s_ady < DeltaW'(s_da)) begin
          if (!s_db[DeltaW-1]) begin
            mode_d = ModeShallowUp;
            dec_d  = s_dbw + s_dbw - s_daw;
          end else begin
            mode_d = ModeShallowDn;
            dec_d  = s_dbw + s_dbw + s_daw;
          end
        end else begin
          if (!s_db[DeltaW-1]) begin
            mode_d = ModeSteepUp;
            dec_d  = s_dbw - s_daw - s_daw;
          end else begin
            mode_d = ModeSteepDn;
            dec_d  = s_dbw + s_daw + s_daw;
          end
        end
      end
      pixel_valid_o = 1'b1;
      pixel_x_o     = sx;
      pixel_y_o     = sy;
    end else if (busy_q) begin
      // advance one pixel along the current octant
      case (mode_q)
        ModeHorz: begin
          cur_x_d   = x_inc;
          step_last = (x_inc == tgt_x_q);
        end
        ModeVert: begin
          cur_y_d   = y_inc;
          step_last = (y_inc == tgt_y_q);
        end
        ModeDiag: begin
          cur_x_d   = x_inc;
          cur_y_d   = y_step;
          step_last = (x_inc == tgt_x_q);
        end
        ModeShallowUp: begin
          cur_x_d = x_inc;
          if (dec_q > 0) begin
            cur_y_d = y_inc;
            dec_d   = dec_q - daw - daw + dbw + dbw;
          end else begin
            dec_d   = dec_q + dbw + dbw;
          end
          step_last = (x_inc == tgt_x_q);
        end
        ModeShallowDn: begin
          cur_x_d = x_inc;
          if (dec_q < 0) begin
            cur_y_d = y_dec;
            dec_d   = dec_q + daw + daw + dbw + dbw;
          end else begin
            dec_d   = dec_q + dbw + dbw;
          end
          step_last = (x_inc == tgt_x_q);
        end
        ModeSteepUp: begin
          cur_y_d = y_inc;
          if (dec_q < 0) begin
            cur_x_d = x_inc;
            dec_d   = dec_q + dbw + dbw - daw - daw;
          end else begin
            dec_d   = dec_q - daw - daw;
          end
          step_last = (y_inc == tgt_y_q);
        end
        ModeSteepDn: begin
          cur_y_d = y_dec;
          if (dec_q > 0) begin
            cur_x_d = x_inc;
            dec_d   = dec_q + dbw + dbw + daw + daw;
          end else begin
            dec_d   = dec_q + daw + daw;
          end
          step_last = (y_dec == tgt_y_q);
        end
        default: begin
          step_last = 1'b1;
        end
      endcase
      busy_d        = !step_last;
      pixel_valid_o = 1'b1;
      pixel_x_o     = cur_x_d;
      pixel_y_o     = cur_y_d;
      last_pixel_o  = step_last;
    end
  end

  // update line state as each word passes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= '0;
      cur_y_q <= '0;
      tgt_x_q <= '0;
      tgt_y_q <= '0;
      dec_q   <= '0;
      da_q    <= '0;
      db_q    <= '0;
      mode_q  <= ModeHorz;
      busy_q  <= 1'b0;
    end else if (fire_i) begin
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      tgt_x_q <= tgt_x_d;
      tgt_y_q <= tgt_y_d;
      dec_q   <= dec_d;
      da_q    <= da_d;
      db_q    <= db_d;
      mode_q  <= mode_d;
      busy_q  <= busy_d;
    end
  end

endmodule : bls_raster
`default_nettype wire

[rtl/bls_out_stage.sv]
// Output register of the line stepper: holds one result word until the sink takes it.
`default_nettype none
module bls_out_stage import bls_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  load_i,
  output      logic                  advance_o,
  input  wire logic                  pixel_valid_i,
  input  wire logic [COORD_BITS-1:0] pixel_x_i,
  input  wire logic [COORD_BITS-1:0] pixel_y_i,
  input  wire logic                  last_pixel_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic                  pixel_valid_o,
  output      logic [COORD_BITS-1:0] pixel_x_o,
  output      logic [COORD_BITS-1:0] pixel_y_o,
  output      logic                  last_pixel_o
);

  logic                  vld_q;
  logic                  pv_q, last_q;
  logic [COORD_BITS-1:0] px_q, py_q;

  // room for a new word when empty or draining now
  assign advance_o = !vld_q || out_ready_i;

  // hold the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load_i) begin
      vld_q <= 1'b1;
    end else if (out_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  // capture the result word
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pv_q   <= pixel_valid_i;
      px_q   <= pixel_x_i;
      py_q   <= pixel_y_i;
      last_q <= last_pixel_i;
    end
  end

  assign out_valid_o   = vld_q;
  assign pixel_valid_o = pv_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign last_pixel_o  = last_q;

endmodule : bls_out_stage
`default_nettype wire
